@@ design/irlm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlm_pkg
// Shared widths, constants and control types of the idle rate load meter.
// ----------------------------------------------------------------------------
package irlm_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned HALF_W    = DATA_W / 2;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned NUM_CORES = 2;
  localparam int unsigned LOAD_W    = 7;
  localparam int unsigned K_W       = 20;
  localparam int unsigned MUL_W     = HALF_W + K_W;
  localparam int unsigned CNT_W     = $clog2(DATA_W);

  localparam logic [K_W-1:0]    US_PER_SEC = K_W'(1000000);
  localparam logic [K_W-1:0]    PCT_SCALE  = K_W'(100);
  localparam logic [LOAD_W-1:0] PCT_FULL   = LOAD_W'(100);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD_OP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_DIV_END,
    ST_PEAK,
    ST_NEXT,
    ST_COMMIT,
    ST_OUT
  } irlm_state_t;

  typedef struct packed {
    logic load_in;
    logic load_op;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic div_end;
    logic clear_pct;
    logic commit;
    logic load_out;
    logic core;
    logic phase;
  } irlm_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_sat;
    logic div_last;
    logic peak_zero;
    logic out_free;
  } irlm_status_t;

endpackage

@@ design/irlm_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlm sample and load channels
// Valid/ready channels carrying one sample item and one load result item.
// ----------------------------------------------------------------------------
interface irlm_sample_if;
  logic        valid;
  logic        ready;
  logic [63:0] now_us;
  logic [63:0] idle_count_core0;
  logic [63:0] idle_count_core1;

  modport source (output valid, now_us, idle_count_core0, idle_count_core1, input ready);
  modport sink   (input valid, now_us, idle_count_core0, idle_count_core1, output ready);
endinterface

interface irlm_load_if;
  logic       valid;
  logic       ready;
  logic [6:0] load_core0;
  logic [6:0] load_core1;

  modport source (output valid, load_core0, load_core1, input ready);
  modport sink   (input valid, load_core0, load_core1, output ready);
endinterface

@@ design/irlm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlm_ctrl
// Sequencer: per core, rate = delta*1e6/dt, then ratio = rate*100/peak,
// each a two-step multiply followed by a bit-serial divide.
// ----------------------------------------------------------------------------
module irlm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  irlm_pkg::irlm_status_t status,
  output irlm_pkg::irlm_cmd_t    cmd
);
  import irlm_pkg::*;

  irlm_state_t state, state_next;
  logic        core, core_next;
  logic        phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      core  <= 1'b0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      core  <= core_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    core_next  = core;
    phase_next = phase;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.core   = core;
    cmd.phase  = phase;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        // a sample with no elapsed time is dropped
        core_next  = 1'b0;
        phase_next = 1'b0;
        state_next = status.dt_zero ? ST_IDLE : ST_LOAD_OP;
      end
      ST_LOAD_OP: begin
        cmd.load_op = 1'b1;
        state_next  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = status.div_sat ? ST_DIV_END : ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_DIV_END;
      end
      ST_DIV_END: begin
        cmd.div_end = 1'b1;
        state_next  = phase ? ST_NEXT : ST_PEAK;
      end
      ST_PEAK: begin
        if (status.peak_zero) begin
          cmd.clear_pct = 1'b1;
          state_next    = ST_NEXT;
        end else begin
          phase_next = 1'b1;
          state_next = ST_LOAD_OP;
        end
      end
      ST_NEXT: begin
        if (!core) begin
          core_next  = 1'b1;
          phase_next = 1'b0;
          state_next = ST_LOAD_OP;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample taken while a sample is in progress");

  a_run_not_sat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_RUN) |-> !status.div_sat)
    else $error("divider iterating on an overflowing quotient");

  a_commit_last_core: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT) |-> (core == 1'b1 && $past(state) == ST_NEXT))
    else $error("state committed before both cores were done");

endmodule

@@ design/irlm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlm_dp
// Datapath: sample and history registers, a 32x20 multiplier used twice per
// product, a restoring divider one quotient bit per cycle, result register.
// ----------------------------------------------------------------------------
module irlm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  irlm_pkg::irlm_cmd_t            cmd,
  output irlm_pkg::irlm_status_t         status,
  input  logic [irlm_pkg::DATA_W-1:0]   now_us,
  input  logic [irlm_pkg::DATA_W-1:0]   idle_count_core0,
  input  logic [irlm_pkg::DATA_W-1:0]   idle_count_core1,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [irlm_pkg::LOAD_W-1:0]   load_core0,
  output logic [irlm_pkg::LOAD_W-1:0]   load_core1
);
  import irlm_pkg::*;

  // sample and history
  logic [DATA_W-1:0] now_r;
  logic [DATA_W-1:0] cnt_r     [NUM_CORES];
  logic [DATA_W-1:0] prev_time;
  logic [DATA_W-1:0] prev_idle [NUM_CORES];
  logic [DATA_W-1:0] peak      [NUM_CORES];
  logic [LOAD_W-1:0] pct       [NUM_CORES];
  logic [DATA_W-1:0] rate_r;

  // arithmetic
  logic [DATA_W-1:0] mul_a;
  logic [K_W-1:0]    k;
  logic [DATA_W-1:0] div_d;
  logic [PROD_W-1:0] acc;
  logic [HALF_W-1:0] mul_x;
  logic [MUL_W-1:0]  mul_p;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvd_lo;
  logic [DATA_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem_sh;
  logic              rem_top;
  logic              take;
  logic [DATA_W-1:0] delta;

  assign delta   = cnt_r[cmd.core] - prev_idle[cmd.core];
  assign mul_x   = cmd.mul_hi ? mul_a[DATA_W-1:HALF_W] : mul_a[HALF_W-1:0];
  assign mul_p   = mul_x * k;
  assign rem_top = rem[DATA_W-1];
  assign rem_sh  = {rem[DATA_W-2:0], dvd_lo[DATA_W-1]};
  assign take    = rem_top || (rem_sh >= div_d);

  assign status.dt_zero   = (now_r == prev_time);
  assign status.div_sat   = (acc[PROD_W-1:DATA_W] >= div_d);
  assign status.div_last  = (cnt == {CNT_W{1'b1}});
  assign status.peak_zero = (peak[cmd.core] == '0);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r    <= now_us;
      cnt_r[0] <= idle_count_core0;
      cnt_r[1] <= idle_count_core1;
    end
    if (cmd.load_op) begin
      mul_a <= cmd.phase ? rate_r : delta;
      div_d <= cmd.phase ? peak[cmd.core] : (now_r - prev_time);
      k     <= cmd.phase ? PCT_SCALE : US_PER_SEC;
    end
    if (cmd.mul_lo) acc <= PROD_W'(mul_p);
    if (cmd.mul_hi) acc <= acc + (PROD_W'(mul_p) << HALF_W);
    if (cmd.div_init) begin
      if (status.div_sat) begin
        quo <= '1;
      end else begin
        rem    <= acc[PROD_W-1:DATA_W];
        dvd_lo <= acc[DATA_W-1:0];
        quo    <= '0;
        cnt    <= '0;
      end
    end
    if (cmd.div_step) begin
      rem    <= take ? (rem_sh - div_d) : rem_sh;
      dvd_lo <= {dvd_lo[DATA_W-2:0], 1'b0};
      quo    <= {quo[DATA_W-2:0], take};
      cnt    <= cnt + CNT_W'(1);
    end
    if (cmd.div_end) begin
      if (!cmd.phase) begin
        rate_r <= quo;
      end else begin
        pct[cmd.core] <= (quo >= DATA_W'(PCT_FULL)) ? '0 : PCT_FULL - quo[LOAD_W-1:0];
      end
    end
    if (cmd.clear_pct) pct[cmd.core] <= '0;
    if (cmd.load_out) begin
      load_core0 <= pct[0];
      load_core1 <= pct[1];
    end
  end

  // history and peaks
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time    <= '0;
      prev_idle[0] <= '0;
      prev_idle[1] <= '0;
      peak[0]      <= '0;
      peak[1]      <= '0;
    end else begin
      if (cmd.div_end && !cmd.phase && (quo > peak[cmd.core])) peak[cmd.core] <= quo;
      if (cmd.commit) begin
        prev_time    <= now_r;
        prev_idle[0] <= cnt_r[0];
        prev_idle[1] <= cnt_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_load_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (load_core0 <= PCT_FULL && load_core1 <= PCT_FULL))
    else $error("load above full scale");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (peak[0] >= $past(peak[0]) && peak[1] >= $past(peak[1])))
    else $error("peak rate decreased");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

endmodule

@@ design/idle_rate_cpu_load_meter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_rate_cpu_load_meter_unit
// Two-core busy percentage from periodic idle-loop count samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample: one item per sampling period with a microsecond timestamp and the
//   free-running idle counts of both cores. result: one item with load_core0
//   and load_core1 (0..100) for every sample whose timestamp differs from the
//   last accepted one; a sample with the same timestamp gives no item.
//   The block works on one sample at a time. sample.ready is high only while
//   idle; it returns to idle only once the result is handed over or the
//   sample is dropped. Per sample, each core needs two divides (idle rate,
//   then rate against peak) on one 64-step bit-serial divider, each after a
//   multiply in low and high halves on one 32x20 multiplier; a divide whose
//   quotient overflows skips the bit-serial steps, and a core whose peak is
//   still zero skips its second divide. A sample with zero elapsed time is
//   dropped after the timestamp check.
//   The result register holds its item until taken; a stalled receiver holds
//   off the hand-over and the next sample's accept, not the computation.
//   Reset clears the time and count baselines and both peaks to zero.
// ----------------------------------------------------------------------------
module idle_rate_cpu_load_meter_unit (
  input  logic         clk,
  input  logic         rst,
  irlm_sample_if.sink  sample,
  irlm_load_if.source  result
);
  import irlm_pkg::*;

  irlm_cmd_t    cmd;
  irlm_status_t status;
  logic         in_ready;

  assign sample.ready = in_ready;

  irlm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  irlm_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .now_us           (sample.now_us),
    .idle_count_core0 (sample.idle_count_core0),
    .idle_count_core1 (sample.idle_count_core1),
    .out_ready        (result.ready),
    .out_valid        (result.valid),
    .load_core0       (result.load_core0),
    .load_core1       (result.load_core1)
  );

endmodule
